// File: rtl/core/pidcs_pkg.sv
package pidcs_pkg;

    localparam int FIELD_W   = 32;
    localparam int DATA_W    = 32;
    localparam int ACCUM_W   = 48;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PARAM_W   = 31;
    localparam int FRAC_W    = 16;
    localparam int LO_W      = 32;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = DATA_W + ACCUM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP         = 3'd0,
        REG_GAIN_INTEG        = 3'd1,
        REG_GAIN_DERIV        = 3'd2,
        REG_SAMPLE_PERIOD     = 3'd3,
        REG_INV_SAMPLE_PERIOD = 3'd4,
        REG_OUTPUT_LIMIT      = 3'd5,
        REG_INTEG_DEADBAND    = 3'd6
    } t_reg_idx;

    localparam logic signed [CFG_W-1:0] RST_GAIN_PROP         = 32'sd65536;
    localparam logic signed [CFG_W-1:0] RST_GAIN_INTEG        = 32'sd0;
    localparam logic signed [CFG_W-1:0] RST_GAIN_DERIV        = 32'sd0;
    localparam logic [PARAM_W-1:0]      RST_SAMPLE_PERIOD     = 31'd65536;
    localparam logic [PARAM_W-1:0]      RST_INV_SAMPLE_PERIOD = 31'd65536;
    localparam logic [PARAM_W-1:0]      RST_OUTPUT_LIMIT      = 31'd6553600;
    localparam logic [PARAM_W-1:0]      RST_INTEG_DEADBAND    = 31'd655;

    typedef struct packed {
        logic signed [FIELD_W-1:0] setpoint;
        logic signed [FIELD_W-1:0] measured;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] drive;
        logic                      clamped;
    } t_out;

    typedef struct packed {
        logic signed [CFG_W-1:0] gain_prop;
        logic signed [CFG_W-1:0] gain_integ;
        logic signed [CFG_W-1:0] gain_deriv;
        logic [PARAM_W-1:0]      sample_period;
        logic [PARAM_W-1:0]      inv_sample_period;
        logic [PARAM_W-1:0]      output_limit;
        logic [PARAM_W-1:0]      integ_deadband;
    } t_cfg;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PER  = 9'b000000010,
        S_INV  = 9'b000000100,
        S_GP   = 9'b000001000,
        S_GD   = 9'b000010000,
        S_GILO = 9'b000100000,
        S_GIHI = 9'b001000000,
        S_ADD  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        MSEL_PER  = 3'd0,
        MSEL_INV  = 3'd1,
        MSEL_GP   = 3'd2,
        MSEL_GD   = 3'd3,
        MSEL_GILO = 3'd4,
        MSEL_GIHI = 3'd5
    } t_msel;

    typedef struct packed {
        logic  accept;
        t_msel mul_sel;
        logic  load_diff;
        logic  upd_integ;
        logic  load_deriv;
        logic  acc_init;
        logic  acc_add;
        logic  acc_add_hi;
        logic  finish;
    } t_ctrl;

endpackage

// File: rtl/core/pidcs_cfg.sv
module pidcs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pidcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pidcs_pkg::CFG_W-1:0]        i_cfg_data,
    output pidcs_pkg::t_cfg                    o_cfg
);
    import pidcs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_PROP:         n_cfg.gain_prop         = i_cfg_data;
                REG_GAIN_INTEG:        n_cfg.gain_integ        = i_cfg_data;
                REG_GAIN_DERIV:        n_cfg.gain_deriv        = i_cfg_data;
                REG_SAMPLE_PERIOD:     n_cfg.sample_period     = i_cfg_data[PARAM_W-1:0];
                REG_INV_SAMPLE_PERIOD: n_cfg.inv_sample_period = i_cfg_data[PARAM_W-1:0];
                REG_OUTPUT_LIMIT:      n_cfg.output_limit      = i_cfg_data[PARAM_W-1:0];
                REG_INTEG_DEADBAND:    n_cfg.integ_deadband    = i_cfg_data[PARAM_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop         <= RST_GAIN_PROP;
            r_cfg.gain_integ        <= RST_GAIN_INTEG;
            r_cfg.gain_deriv        <= RST_GAIN_DERIV;
            r_cfg.sample_period     <= RST_SAMPLE_PERIOD;
            r_cfg.inv_sample_period <= RST_INV_SAMPLE_PERIOD;
            r_cfg.output_limit      <= RST_OUTPUT_LIMIT;
            r_cfg.integ_deadband    <= RST_INTEG_DEADBAND;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pidcs_mul.sv
module pidcs_mul (
    input  logic                                   i_clk,
    input  logic signed [pidcs_pkg::MUL_W-1:0]     i_a,
    input  logic signed [pidcs_pkg::MUL_W-1:0]     i_b,
    output logic signed [pidcs_pkg::PROD_W-1:0]    o_prod
);
    import pidcs_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/pidcs_ctrl.sv
module pidcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_busy,
    output logic              o_in_stall,
    output pidcs_pkg::t_ctrl  o_ctrl
);
    import pidcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PER;
                end
            end
            S_PER:  n_state = S_INV;
            S_INV:  n_state = S_GP;
            S_GP:   n_state = S_GD;
            S_GD:   n_state = S_GILO;
            S_GILO: n_state = S_GIHI;
            S_GIHI: n_state = S_ADD;
            S_ADD:  n_state = S_DONE;
            S_DONE: begin
                if (!i_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctrl            = '0;
        o_ctrl.mul_sel    = MSEL_PER;
        o_ctrl.accept     = (r_state == S_IDLE) && i_in_valid;
        o_ctrl.load_diff  = (r_state == S_PER);
        o_ctrl.upd_integ  = (r_state == S_INV);
        o_ctrl.load_deriv = (r_state == S_GP);
        o_ctrl.acc_init   = (r_state == S_GD);
        o_ctrl.acc_add    = (r_state == S_GILO) || (r_state == S_GIHI);
        o_ctrl.acc_add_hi = (r_state == S_ADD);
        o_ctrl.finish     = (r_state == S_DONE) && !i_out_busy;
        case (r_state)
            S_PER:   o_ctrl.mul_sel = MSEL_PER;
            S_INV:   o_ctrl.mul_sel = MSEL_INV;
            S_GP:    o_ctrl.mul_sel = MSEL_GP;
            S_GD:    o_ctrl.mul_sel = MSEL_GD;
            S_GILO:  o_ctrl.mul_sel = MSEL_GILO;
            S_GIHI:  o_ctrl.mul_sel = MSEL_GIHI;
            default: o_ctrl.mul_sel = MSEL_PER;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/core/pidcs_dp.sv
module pidcs_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pidcs_pkg::t_ctrl                       i_ctrl,
    input  pidcs_pkg::t_cfg                        i_cfg,
    input  pidcs_pkg::t_in                         i_in_request,
    input  logic                                   i_out_stall,
    input  logic signed [pidcs_pkg::PROD_W-1:0]    i_prod,
    output logic signed [pidcs_pkg::MUL_W-1:0]     o_mul_a,
    output logic signed [pidcs_pkg::MUL_W-1:0]     o_mul_b,
    output logic                                   o_out_valid,
    output pidcs_pkg::t_out                        o_out_request
);
    import pidcs_pkg::*;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACCUM_W-1:0] ACC_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
    localparam logic signed [ACCUM_W-1:0] ACC_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};

    logic signed [DATA_W-1:0]  r_err;
    logic signed [DATA_W-1:0]  n_err;
    logic signed [DATA_W-1:0]  r_prev;
    logic signed [DATA_W:0]    r_diff;
    logic                      r_mag_gt;
    logic signed [ACCUM_W-1:0] r_integ;
    logic signed [ACCUM_W-1:0] n_integ;
    logic signed [DATA_W-1:0]  r_deriv;
    logic signed [DATA_W-1:0]  n_deriv;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   n_acc;
    logic                      r_out_valid;
    t_out                      r_out;
    t_out                      n_out;

    logic [FIELD_W:0]          in_diff;
    logic [DATA_W:0]           err_mag;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [PROD_W:0]    integ_sum;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;

    // The error is the input difference saturated to the data width.
    always_comb begin
        in_diff = {i_in_request.setpoint[FIELD_W-1], i_in_request.setpoint}
                - {i_in_request.measured[FIELD_W-1], i_in_request.measured};
        if ((in_diff[FIELD_W:DATA_W-1] == '0) || (in_diff[FIELD_W:DATA_W-1] == '1)) begin
            n_err = in_diff[DATA_W-1:0];
        end else if (in_diff[FIELD_W]) begin
            n_err = DATA_MIN;
        end else begin
            n_err = DATA_MAX;
        end
    end

    assign err_mag = r_err[DATA_W-1] ? -{r_err[DATA_W-1], r_err} : {1'b0, r_err};

    always_comb begin
        case (i_ctrl.mul_sel)
            MSEL_PER: begin
                o_mul_a = {r_err[DATA_W-1], r_err};
                o_mul_b = {{(MUL_W-PARAM_W){1'b0}}, i_cfg.sample_period};
            end
            MSEL_INV: begin
                o_mul_a = r_diff;
                o_mul_b = {{(MUL_W-PARAM_W){1'b0}}, i_cfg.inv_sample_period};
            end
            MSEL_GP: begin
                o_mul_a = {{(MUL_W-CFG_W){i_cfg.gain_prop[CFG_W-1]}}, i_cfg.gain_prop};
                o_mul_b = {r_err[DATA_W-1], r_err};
            end
            MSEL_GD: begin
                o_mul_a = {{(MUL_W-CFG_W){i_cfg.gain_deriv[CFG_W-1]}}, i_cfg.gain_deriv};
                o_mul_b = {r_deriv[DATA_W-1], r_deriv};
            end
            MSEL_GILO: begin
                o_mul_a = {{(MUL_W-CFG_W){i_cfg.gain_integ[CFG_W-1]}}, i_cfg.gain_integ};
                o_mul_b = {{(MUL_W-LO_W){1'b0}}, r_integ[LO_W-1:0]};
            end
            MSEL_GIHI: begin
                o_mul_a = {{(MUL_W-CFG_W){i_cfg.gain_integ[CFG_W-1]}}, i_cfg.gain_integ};
                o_mul_b = {{(MUL_W-(ACCUM_W-LO_W)){r_integ[ACCUM_W-1]}},
                           r_integ[ACCUM_W-1:LO_W]};
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    assign prod_sh   = i_prod >>> FRAC_W;
    assign integ_sum = {{(PROD_W+1-ACCUM_W){r_integ[ACCUM_W-1]}}, r_integ}
                     + {prod_sh[PROD_W-1], prod_sh};

    always_comb begin
        n_integ = r_integ;
        if (i_ctrl.upd_integ && r_mag_gt) begin
            if ((integ_sum[PROD_W:ACCUM_W-1] == '0) || (integ_sum[PROD_W:ACCUM_W-1] == '1)) begin
                n_integ = integ_sum[ACCUM_W-1:0];
            end else if (integ_sum[PROD_W]) begin
                n_integ = ACC_MIN;
            end else begin
                n_integ = ACC_MAX;
            end
        end
    end

    always_comb begin
        if ((prod_sh[PROD_W-1:DATA_W-1] == '0) || (prod_sh[PROD_W-1:DATA_W-1] == '1)) begin
            n_deriv = prod_sh[DATA_W-1:0];
        end else if (prod_sh[PROD_W-1]) begin
            n_deriv = DATA_MIN;
        end else begin
            n_deriv = DATA_MAX;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.acc_init) begin
            n_acc = {{(SUM_W-PROD_W){i_prod[PROD_W-1]}}, i_prod};
        end else if (i_ctrl.acc_add) begin
            n_acc = r_acc + {{(SUM_W-PROD_W){i_prod[PROD_W-1]}}, i_prod};
        end else if (i_ctrl.acc_add_hi) begin
            n_acc = r_acc + {i_prod[SUM_W-LO_W-1:0], {LO_W{1'b0}}};
        end
    end

    assign sum     = r_acc >>> FRAC_W;
    assign lim_pos = {{(SUM_W-PARAM_W){1'b0}}, i_cfg.output_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        n_out.drive   = sum[FIELD_W-1:0];
        n_out.clamped = 1'b0;
        if (sum > lim_pos) begin
            n_out.drive   = lim_pos[FIELD_W-1:0];
            n_out.clamped = 1'b1;
        end else if (sum < lim_neg) begin
            n_out.drive   = lim_neg[FIELD_W-1:0];
            n_out.clamped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_err <= n_err;
        end
        if (i_ctrl.load_diff) begin
            r_diff   <= {r_err[DATA_W-1], r_err} - {r_prev[DATA_W-1], r_prev};
            r_mag_gt <= err_mag > {{(DATA_W+1-PARAM_W){1'b0}}, i_cfg.integ_deadband};
        end
        if (i_ctrl.load_deriv) begin
            r_deriv <= n_deriv;
        end
        r_acc <= n_acc;
        if (i_ctrl.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.load_diff) begin
                r_prev <= r_err;
            end
            r_integ <= n_integ;
            if (i_ctrl.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_request = r_out;

endmodule

// File: rtl/core/pid_controller_step_core.sv
// PID controller step, clamped drive output, signed Q16.16 data and gains.
// The input channel takes a request of setpoint and measured value when
// i_in_valid is high and o_in_stall is low. The output channel presents the
// clamped drive and the clamp flag on o_out_request while o_out_valid is high,
// and the request is taken when i_out_stall is low.
// One 33 by 33 bit multiplier is shared by all six products of an update, so
// an accepted request is worked through step by step, and a new request is
// taken only once the sequencer is back in idle.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; the sequencer only holds in its last
// step when the output register is still full and stalled.
// The user must write the gains, periods, limit and deadband through i_cfg_we,
// i_cfg_idx and i_cfg_data while no request is in flight; the block does not
// enforce this. Reset clears the previous error and the integral, restores
// the register defaults and empties the output register.
module pid_controller_step_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  pidcs_pkg::t_in                     i_in_request,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output pidcs_pkg::t_out                    o_out_request,
    input  logic                               i_out_stall,
    input  logic                               i_cfg_we,
    input  logic [pidcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pidcs_pkg::CFG_W-1:0]        i_cfg_data
);
    import pidcs_pkg::*;

    t_cfg                     cfg;
    t_ctrl                    ctrl;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     out_busy;

    assign out_busy = o_out_valid && i_out_stall;

    pidcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pidcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (out_busy),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    pidcs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pidcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cfg         (cfg),
        .i_in_request  (i_in_request),
        .i_out_stall   (i_out_stall),
        .i_prod        (prod),
        .o_mul_a       (mul_a),
        .o_mul_b       (mul_b),
        .o_out_valid   (o_out_valid),
        .o_out_request (o_out_request)
    );

endmodule
